/* design/oil_pkg.sv */
// Shared types, codes and defaults for the ordered item list.
`timescale 1ns / 1ps
`default_nettype none

package oil_pkg;

    // Fixed field widths of the request and response payloads
    localparam int ACT_W     = 3;
    localparam int ITEM_IO_W = 32;
    localparam int POS_W     = 5;
    localparam int ST_W      = 3;
    localparam int CNT_W     = 5;

    // Defaults for the top-level parameters
    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_ITEM_WIDTH = 32;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_PUSH       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_POP        = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REMOVE_ALL = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REMOVE_AT  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_FIND       = 3'd5;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0]     action;
        logic [ITEM_IO_W-1:0] item_value;
        logic [POS_W-1:0]     position;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic [ITEM_IO_W-1:0] item_out;
        logic [POS_W-1:0]     position_out;
        logic                 found;
        logic [CNT_W-1:0]     entry_count;
    } t_rsp;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch request and build match vector
        logic exec;     // perform the requested action, load response
        logic step;     // drop the first matching entry
        logic finish;   // load the remove-all response
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic remove_all;
        logic match_any;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

/* design/oil_ifs.sv */
// Request and response channel interfaces of the ordered item list.
`timescale 1ns / 1ps
`default_nettype none

interface oil_req_if;
    import oil_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface oil_rsp_if;
    import oil_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/ordered_item_list.sv */
// Top level of the ordered item list: controller and datapath.
//
//   channel  dir  modport  payload
//   i_req    in   sink     action, item_value, position
//   o_rsp    out  source   status, item_out, position_out, found, entry_count
//
// A request is accepted, then executed in a separate state that loads the
// response register. Remove-all-equal passes through execute to a compact
// state that drops one matching entry per step in the cells, then reports.
// Reset (synchronous, active low) clears the count and the response valid;
// cell contents are not cleared. A stalled response holds in its register;
// the next request is accepted meanwhile and waits in execute until it frees.
`timescale 1ns / 1ps
`default_nettype none

module ordered_item_list #(
    parameter int CAPACITY   = oil_pkg::DEF_CAPACITY,
    parameter int ITEM_WIDTH = oil_pkg::DEF_ITEM_WIDTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    oil_req_if.sink    i_req,
    oil_rsp_if.source  o_rsp
);
    import oil_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequence requests
    oil_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Store entries and build responses
    oil_dp #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (i_req.data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_rsp_data  (o_rsp.data)
    );

endmodule

`default_nettype wire

/* design/oil_ctrl.sv */
// Controller state machine of the ordered item list.
`timescale 1ns / 1ps
`default_nettype none

module oil_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    output logic                o_req_ready,
    input  wire oil_pkg::t_stat i_stat,
    output oil_pkg::t_cmd       o_cmd
);
    import oil_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_EXEC    = 3'b010,
        S_COMPACT = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Sequence one request: accept, execute, optionally compact
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.remove_all) begin
                    n_state = S_COMPACT;
                end else if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_COMPACT: begin
                if (i_stat.match_any) begin
                    o_cmd.step = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* design/oil_dp.sv */
// Datapath of the ordered item list: shifting cells, match vector, response register.
`timescale 1ns / 1ps
`default_nettype none

module oil_dp #(
    parameter int CAPACITY   = oil_pkg::DEF_CAPACITY,
    parameter int ITEM_WIDTH = oil_pkg::DEF_ITEM_WIDTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire oil_pkg::t_req  i_req_data,
    input  wire oil_pkg::t_cmd  i_cmd,
    output oil_pkg::t_stat      o_stat,
    input  wire logic           i_rsp_ready,
    output logic                o_rsp_valid,
    output oil_pkg::t_rsp       o_rsp_data
);
    import oil_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    logic [ITEM_WIDTH-1:0] r_cell [CAPACITY];
    logic [ITEM_WIDTH-1:0] n_cell [CAPACITY];
    logic [ITEM_WIDTH-1:0] w_below [CAPACITY];
    logic [ITEM_WIDTH-1:0] w_above [CAPACITY];
    logic [CAPACITY-1:0]   w_hit;
    logic [CAPACITY-1:0]   w_match_above;
    logic [CAPACITY-1:0]   r_match, n_match;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_removed, n_removed;
    logic [ACT_W-1:0]      r_act;
    logic [ITEM_WIDTH-1:0] r_val;
    logic [POS_W-1:0]      r_pos;
    logic                  r_out_valid;
    t_rsp                  r_rsp, n_rsp;

    logic [ITEM_WIDTH-1:0] in_val;
    logic [IW-1:0]         first_idx;
    logic [IW-1:0]         drop_idx;
    logic [CW-1:0]         top_pos;
    logic                  match_any, full, empty, ins_bad, rm_bad, load, out_free;

    assign in_val    = ITEM_WIDTH'(i_req_data.item_value);
    assign match_any = |r_match;
    assign full      = (r_count == CW'(CAPACITY));
    assign empty     = (r_count == '0);
    assign ins_bad   = (XW'(r_pos) > XW'(r_count));
    assign rm_bad    = (XW'(r_pos) >= XW'(r_count));
    assign top_pos   = r_count - CW'(1);
    assign out_free  = !r_out_valid || i_rsp_ready;
    assign load      = i_cmd.exec || i_cmd.finish;

    // Find the lowest matching cell
    always_comb begin
        first_idx = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (r_match[k]) begin
                first_idx = IW'(k);
            end
        end
    end

    // Shift-down origin: explicit position or first match
    assign drop_idx = (r_act == ACT_REMOVE_AT) ? IW'(r_pos) : first_idx;

    // Per-cell neighbors, compare and next value
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_bot
            assign w_below[g] = r_cell[g];
        end else begin : g_mid
            assign w_below[g] = r_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_top
            assign w_above[g]       = r_cell[g];
            assign w_match_above[g] = 1'b0;
        end else begin : g_low
            assign w_above[g]       = r_cell[g+1];
            assign w_match_above[g] = r_match[g+1];
        end

        assign w_hit[g] = (r_cell[g] == in_val) && (CW'(g) < r_count);

        always_comb begin
            n_cell[g]  = r_cell[g];
            n_match[g] = r_match[g];
            if (i_cmd.capture) begin
                n_match[g] = w_hit[g];
            end
            if (i_cmd.exec) begin
                case (r_act)
                    ACT_PUSH: begin
                        if (!full && CW'(g) == r_count) begin
                            n_cell[g] = r_val;
                        end
                    end
                    ACT_INSERT: begin
                        if (!ins_bad && !full) begin
                            if (XW'(g) > XW'(r_pos)) begin
                                n_cell[g] = w_below[g];
                            end else if (XW'(g) == XW'(r_pos)) begin
                                n_cell[g] = r_val;
                            end
                        end
                    end
                    ACT_REMOVE_AT: begin
                        if (!rm_bad && IW'(g) >= drop_idx) begin
                            n_cell[g] = w_above[g];
                        end
                    end
                    default: begin
                        n_cell[g] = r_cell[g];
                    end
                endcase
            end
            // Close up over the first matching entry
            if (i_cmd.step && IW'(g) >= drop_idx) begin
                n_cell[g]  = w_above[g];
                n_match[g] = w_match_above[g];
            end
        end
    end

    // Count, removal tally and response
    always_comb begin
        n_count   = r_count;
        n_removed = r_removed;
        n_rsp     = '0;
        if (i_cmd.capture) begin
            n_removed = '0;
        end
        if (i_cmd.exec) begin
            case (r_act)
                ACT_PUSH: begin
                    if (full) begin
                        n_rsp.status = ST_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
                ACT_POP: begin
                    if (empty) begin
                        n_rsp.status = ST_EMPTY;
                    end else begin
                        n_count        = top_pos;
                        n_rsp.item_out = ITEM_IO_W'(r_cell[top_pos[IW-1:0]]);
                    end
                end
                ACT_INSERT: begin
                    if (ins_bad) begin
                        n_rsp.status = ST_BADPOS;
                    end else if (full) begin
                        n_rsp.status = ST_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
                ACT_REMOVE_AT: begin
                    if (rm_bad) begin
                        n_rsp.status = ST_BADPOS;
                    end else begin
                        n_count = top_pos;
                    end
                end
                ACT_FIND: begin
                    if (match_any) begin
                        n_rsp.position_out = POS_W'(first_idx);
                        n_rsp.found        = 1'b1;
                    end else begin
                        n_rsp.status = ST_NOTFOUND;
                    end
                end
                default: begin
                    n_rsp.status = ST_OK;
                end
            endcase
            n_rsp.entry_count = CNT_W'(n_count);
        end
        if (i_cmd.step) begin
            n_count   = top_pos;
            n_removed = r_removed + CW'(1);
        end
        if (i_cmd.finish) begin
            n_rsp.status       = (r_removed == '0) ? ST_NOTFOUND : ST_OK;
            n_rsp.position_out = POS_W'(r_removed);
            n_rsp.entry_count  = CNT_W'(r_count);
        end
    end

    // Hold cells, match vector, removal tally, latched request and response
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CAPACITY; k++) begin
            r_cell[k] <= n_cell[k];
        end
        r_match   <= n_match;
        r_removed <= n_removed;
        if (i_cmd.capture) begin
            r_act <= i_req_data.action;
            r_val <= in_val;
            r_pos <= i_req_data.position;
        end
        if (load) begin
            r_rsp <= n_rsp;
        end
    end

    // Count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid       = r_out_valid;
    assign o_rsp_data        = r_rsp;
    assign o_stat.remove_all = (r_act == ACT_REMOVE_ALL);
    assign o_stat.match_any  = match_any;
    assign o_stat.out_free   = out_free;

endmodule

`default_nettype wire

/* sim/oil_list_checker.sv */
// Response checker for the ordered item list: tracks the list and compares every response.
`timescale 1ns / 1ps

module oil_list_checker
    import oil_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int ITEM_WIDTH = DEF_ITEM_WIDTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    input  wire logic i_req_ready,
    input  t_req      i_req_data,
    input  wire logic i_rsp_valid,
    input  wire logic i_rsp_ready,
    input  t_rsp      i_rsp_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_rsp_count
);

    localparam logic [ITEM_IO_W-1:0] ITEM_MASK =
        (ITEM_WIDTH >= ITEM_IO_W) ? '1 : ((ITEM_IO_W'(1) << ITEM_WIDTH) - 1);

    // Shadow copy of the list
    logic [ITEM_IO_W-1:0] cells [CAPACITY];
    int                   list_len;

    t_rsp expected_rsps [$];
    int   mismatches;
    int   rsp_total;

    initial begin
        list_len   = 0;
        mismatches = 0;
        rsp_total  = 0;
    end

    // Apply one request to the shadow list and build the response it must produce
    function automatic t_rsp apply_action(input t_req rq);
        t_rsp                 rs;
        logic [ITEM_IO_W-1:0] v;
        int                   pos;
        int                   keep;
        int                   removed;
        int                   i;
        rs      = '0;
        v       = rq.item_value & ITEM_MASK;
        pos     = int'(rq.position);
        keep    = 0;
        removed = 0;
        case (rq.action)
            ACT_PUSH: begin
                if (list_len >= CAPACITY) begin
                    rs.status = ST_FULL;
                end else begin
                    cells[list_len] = v;
                    list_len++;
                end
            end
            ACT_POP: begin
                if (list_len == 0) begin
                    rs.status = ST_EMPTY;
                end else begin
                    list_len--;
                    rs.item_out = cells[list_len];
                end
            end
            ACT_INSERT: begin
                // position is checked before capacity
                if (pos > list_len) begin
                    rs.status = ST_BADPOS;
                end else if (list_len >= CAPACITY) begin
                    rs.status = ST_FULL;
                end else begin
                    for (i = list_len; i > pos; i--) cells[i] = cells[i-1];
                    cells[pos] = v;
                    list_len++;
                end
            end
            ACT_REMOVE_ALL: begin
                // close up the survivors in order
                for (i = 0; i < list_len; i++) begin
                    if (cells[i] == v) begin
                        removed++;
                    end else begin
                        cells[keep] = cells[i];
                        keep++;
                    end
                end
                if (removed == 0) begin
                    rs.status = ST_NOTFOUND;
                end else begin
                    list_len        = keep;
                    rs.position_out = POS_W'(removed);
                end
            end
            ACT_REMOVE_AT: begin
                if (pos >= list_len) begin
                    rs.status = ST_BADPOS;
                end else begin
                    for (i = pos; i + 1 < list_len; i++) cells[i] = cells[i+1];
                    list_len--;
                end
            end
            ACT_FIND: begin
                rs.status = ST_NOTFOUND;
                for (i = 0; i < list_len; i++) begin
                    if (!rs.found && cells[i] == v) begin
                        rs.status       = ST_OK;
                        rs.position_out = POS_W'(i);
                        rs.found        = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        rs.entry_count = CNT_W'(list_len);
        return rs;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            mismatches++;
        end
    endtask

    // Retire responses against the oldest expectation, then log new requests
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            list_len = 0;
            expected_rsps.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                rsp_total++;
                if (expected_rsps.size() == 0) begin
                    $error("response with no request outstanding: 0x%0h", i_rsp_data);
                    mismatches++;
                end else begin
                    want = expected_rsps.pop_front();
                    check_field("status", 32'(want.status), 32'(i_rsp_data.status));
                    check_field("item_out", 32'(want.item_out), 32'(i_rsp_data.item_out));
                    check_field("position_out", 32'(want.position_out),
                                32'(i_rsp_data.position_out));
                    check_field("found", 32'(want.found), 32'(i_rsp_data.found));
                    check_field("entry_count", 32'(want.entry_count),
                                32'(i_rsp_data.entry_count));
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_rsps.push_back(apply_action(i_req_data));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_rsps.size();
        o_rsp_count  <= rsp_total;
    end

endmodule

/* sim/tb_ordered_item_list.sv */
// Testbench top for the ordered item list: clock, reset, request traffic and verdict.
`timescale 1ns / 1ps

module tb_ordered_item_list;
    import oil_pkg::*;

    // Action codes with no operation behind them
    localparam logic [ACT_W-1:0] ACT_NOP_A = 3'd6;
    localparam logic [ACT_W-1:0] ACT_NOP_B = 3'd7;

    localparam int RANDOM_REQS  = 1400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int LONG_HOLD    = 80;
    localparam int HOLD_AT      = 300;
    localparam int DRAIN_AT     = 700;
    localparam int CALM_FROM    = 1200;
    localparam int TAIL_CYCLES  = 40;

    logic i_clk;
    logic i_rst_n;

    oil_req_if req_ch ();
    oil_rsp_if rsp_ch ();

    int  fail_total;
    int  pending;
    int  rsp_seen;
    int  sent;
    int  quiet_cycles;
    int  holds_asked;
    int  holds_served;
    bit  idle_on;
    bit  grow;
    logic [ITEM_IO_W-1:0] pool [4];

    ordered_item_list i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    oil_list_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_ch.valid),
        .i_req_ready  (req_ch.ready),
        .i_req_data   (req_ch.data),
        .i_rsp_valid  (rsp_ch.valid),
        .i_rsp_ready  (rsp_ch.ready),
        .i_rsp_data   (rsp_ch.data),
        .o_fail_count (fail_total),
        .o_pending    (pending),
        .o_rsp_count  (rsp_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d responses pending",
                     quiet_cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Response side: random back-pressure bursts and the long hold when asked
    initial begin
        holds_served = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (holds_asked != holds_served) begin
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                holds_served++;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one request and hold it until accepted; valid stays high afterwards
    task automatic issue_request(input logic [ACT_W-1:0] act,
                                 input logic [ITEM_IO_W-1:0] val,
                                 input logic [POS_W-1:0] pos);
        t_req rq;
        rq.action     = act;
        rq.item_value = val;
        rq.position   = pos;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= rq;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    // Values come mostly from a small pool so that finds and removals hit
    function automatic logic [ITEM_IO_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 5) return pool[$urandom_range(0, 3)];
        if (r == 6) return '0;
        if (r == 7) return '1;
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 4) return POS_W'($urandom_range(0, 4));
        if (r <= 8) return POS_W'($urandom_range(0, DEF_CAPACITY));
        return POS_W'($urandom_range(0, 31));
    endfunction

    // Grow phases favor push and insert, shrink phases favor the removals
    function automatic logic [ACT_W-1:0] pick_action(input bit growing);
        int r;
        r = $urandom_range(0, 99);
        if (growing) begin
            if (r < 35) return ACT_PUSH;
            if (r < 60) return ACT_INSERT;
            if (r < 68) return ACT_POP;
            if (r < 76) return ACT_REMOVE_AT;
            if (r < 83) return ACT_REMOVE_ALL;
            if (r < 98) return ACT_FIND;
        end else begin
            if (r < 8)  return ACT_PUSH;
            if (r < 16) return ACT_INSERT;
            if (r < 41) return ACT_POP;
            if (r < 66) return ACT_REMOVE_AT;
            if (r < 81) return ACT_REMOVE_ALL;
            if (r < 98) return ACT_FIND;
        end
        return (r == 98) ? ACT_NOP_A : ACT_NOP_B;
    endfunction

    initial begin
        logic [ITEM_IO_W-1:0] tag;
        int phase_left;
        int n;
        sent         = 0;
        holds_asked  = 0;
        idle_on      = 1'b1;
        grow         = 1'b1;
        tag          = 32'h5A5A_0001;
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corner cases on the empty list
        issue_request(ACT_POP, '0, '0);
        issue_request(ACT_REMOVE_AT, '0, '0);
        issue_request(ACT_REMOVE_ALL, tag, '0);
        issue_request(ACT_FIND, tag, '0);
        issue_request(ACT_INSERT, '1, 5'd1);
        issue_request(ACT_INSERT, '1, 5'd0);
        issue_request(ACT_NOP_A, tag, '0);
        issue_request(ACT_NOP_B, '1, '1);

        // Fill to capacity with repeats of the tag value
        for (n = 0; n < 13; n++) begin
            issue_request(ACT_PUSH, (n % 3 == 0) ? tag : {n[15:0], ~n[15:0]}, '0);
        end
        issue_request(ACT_INSERT, '0, 5'd0);
        issue_request(ACT_INSERT, tag, 5'd7);

        // Full list: rejects, then removals
        issue_request(ACT_PUSH, tag, '0);
        issue_request(ACT_INSERT, tag, '1);
        issue_request(ACT_INSERT, tag, 5'd16);
        issue_request(ACT_FIND, '1, '0);
        issue_request(ACT_REMOVE_ALL, tag, '0);
        issue_request(ACT_REMOVE_AT, '0, '1);
        issue_request(ACT_REMOVE_AT, '0, 5'd0);
        issue_request(ACT_POP, '0, '0);

        // Random traffic in alternating grow and shrink phases
        phase_left = 0;
        for (n = 0; n < RANDOM_REQS; n++) begin
            if (phase_left == 0) begin
                grow       = !grow;
                phase_left = $urandom_range(40, 80);
                foreach (pool[k]) pool[k] = $urandom;
            end
            phase_left--;
            idle_on = (n < CALM_FROM) && ((n / 150) % 4 != 3);
            if (n == HOLD_AT) holds_asked++;
            if (n == DRAIN_AT) begin
                req_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            issue_request(pick_action(grow), pick_value(), pick_position());
        end
        req_ch.valid <= 1'b0;

        // Let the last responses drain
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: empty and full list corners, all actions, unused codes,",
                 sent);
        $display("grow and shrink phases, a long response stall and a full drain; %0d responses",
                 rsp_seen);
        if (fail_total == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", fail_total);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
